// ===== src/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
package tcw_pkg;

   // Field widths of the request and response transactions
   localparam int MODE_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 11;
   localparam int CURSOR_W = 11;
   localparam int CELL_W   = 16;
   localparam int TDATA_W  = 32;

   // Character codes with a meaning of their own
   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'd32;

   // Operation selected by req_tuser
   typedef enum logic [1:0] {
      MODE_PUT   = 2'd0,
      MODE_READ  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_BACK  = 2'd3
   } mode_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_COPY,
      ST_ZERO
   } state_type;

   // Request payload, last field in the lowest bits
   typedef struct packed {
      logic [INDEX_W-1:0] read_index;
      logic [BYTE_W-1:0]  attribute;
      logic [BYTE_W-1:0]  char_code;
   } req_type;

   // Response payload, last field in the lowest bits
   typedef struct packed {
      logic               scrolled;
      logic [BYTE_W-1:0]  cell_attr;
      logic [BYTE_W-1:0]  cell_char;
      logic [CURSOR_W-1:0] cursor;
   } rsp_type;

endpackage

// ===== src/text_console_writer.sv =====
// Top level of the text console writer: cell store, cursor and command sequencer.
//
//  channel   direction  accepted when               carries
//  req_*     in         req_tvalid && req_tready     command (tuser) and its operands
//  rsp_*     out        rsp_tvalid && rsp_tready     cursor, read cell, scroll flag
//
// Sequence per transaction: put, newline and backspace pass through EXEC, read adds READ; a put with the cursor
// at the end scrolls first through COPY and ZERO, then redoes the put in EXEC; clear walks every cell in CLEAR.
// Scroll and clear are walks of the single cell RAM, one cell per cycle through its one
// write port, with the copy reading one row ahead of the write.
// After reset a clearing pass zeroes every cell of the RAM; req_tready stays low meanwhile.
// One command at a time; a new one is taken while the previous response still waits,
// and its execution holds until the response register is free.
module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                         clock,
   input  logic                         reset,
   // Request: tuser = mode; tdata = char_code[7:0], attribute[15:8], read_index[26:16]
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [tcw_pkg::MODE_W-1:0]   req_tuser,
   input  logic [tcw_pkg::TDATA_W-1:0]  req_tdata,
   // Response: tdata = cursor[10:0], cell_char[18:11], cell_attr[26:19], scrolled[27]
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [tcw_pkg::TDATA_W-1:0]  rsp_tdata
);

   localparam int Cells   = ROWS * COLUMNS;
   localparam int MoveN   = Cells - COLUMNS;       // cells moved by a scroll
   localparam int AW      = $clog2(Cells);         // RAM address width
   localparam int PW      = $clog2(Cells + 1);     // cursor width, holds Cells itself
   localparam int CLW     = $clog2(COLUMNS);       // column width
   localparam int CurW    = tcw_pkg::CURSOR_W;
   localparam int CellW   = tcw_pkg::CELL_W;
   localparam int ReqW    = $bits(tcw_pkg::req_type);
   localparam int RspW    = $bits(tcw_pkg::rsp_type);

   // Registers
   tcw_pkg::state_type  state_ff, state_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       pend_addr_ff, pend_addr_in;
   logic [PW-1:0]       cursor_ff, cursor_in;
   logic [CLW-1:0]      col_ff, col_in;
   logic                report_ff, report_in;
   logic                scrolled_ff, scrolled_in;
   logic                rd_ok_ff, rd_ok_in;
   tcw_pkg::mode_type   mode_ff, mode_in;
   tcw_pkg::req_type    req_ff, req_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_type    rsp_ff, rsp_in;

   // RAM port signals
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [CellW-1:0]    wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [CellW-1:0]    rd_data;

   // Helpers
   logic                out_free;
   logic                idx_last;
   logic                copy_more;
   logic [PW-1:0]       bs_cursor;
   logic [CLW-1:0]      bs_col;
   logic [31:0]         ridx_wide;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign idx_last   = (idx_ff == AW'(Cells - 1));
   assign copy_more  = (idx_ff < AW'(MoveN));
   assign ridx_wide  = 32'(req_ff.read_index);
   assign bs_cursor  = (cursor_ff == '0) ? '0 : cursor_ff - PW'(1);
   assign bs_col     = (cursor_ff == '0) ? '0 :
                       (col_ff == '0) ? CLW'(COLUMNS - 1) : col_ff - CLW'(1);

   // Cell store
   tcw_ram #(
      .WIDTH (CellW),
      .DEPTH (Cells)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            if (idx_last) state_in = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = tcw_pkg::ST_EXEC;
         end
         tcw_pkg::ST_EXEC: begin
            if (out_free) begin
               unique case (mode_ff)
                  tcw_pkg::MODE_PUT: begin
                     state_in = (cursor_ff >= PW'(Cells)) ? tcw_pkg::ST_COPY
                                                          : tcw_pkg::ST_IDLE;
                  end
                  tcw_pkg::MODE_READ:  state_in = tcw_pkg::ST_READ;
                  tcw_pkg::MODE_CLEAR: state_in = tcw_pkg::ST_CLEAR;
                  tcw_pkg::MODE_BACK:  state_in = tcw_pkg::ST_IDLE;
               endcase
            end
         end
         tcw_pkg::ST_READ: state_in = tcw_pkg::ST_IDLE;
         tcw_pkg::ST_COPY: begin
            if (!copy_more) state_in = tcw_pkg::ST_ZERO;
         end
         tcw_pkg::ST_ZERO: begin
            if (idx_last) state_in = tcw_pkg::ST_EXEC;
         end
         default: state_in = tcw_pkg::ST_IDLE;
      endcase
   end

   // Datapath, RAM control and response load
   always_comb begin
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      cursor_in    = cursor_ff;
      col_in       = col_ff;
      report_in    = report_ff;
      scrolled_in  = scrolled_ff;
      rd_ok_in     = rd_ok_ff;
      mode_in      = mode_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      req_tready   = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      // Pending scroll copy: write back the cell read in the previous cycle
      wr_en        = pend_ff;
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data;

      unique case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = '0;
            idx_in  = idx_ff + AW'(1);
            if (idx_last) begin
               idx_in    = '0;
               cursor_in = '0;
               col_in    = '0;
               report_in = 1'b0;
               if (report_ff) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in           = '0;
               end
            end
         end
         tcw_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               mode_in     = tcw_pkg::mode_type'(req_tuser);
               req_in      = req_tdata[ReqW-1:0];
               scrolled_in = 1'b0;
            end
         end
         tcw_pkg::ST_EXEC: begin
            if (out_free) begin
               unique case (mode_ff)
                  tcw_pkg::MODE_PUT: begin
                     if (cursor_ff >= PW'(Cells)) begin
                        idx_in = '0;
                     end else begin
                        if (req_ff.char_code == tcw_pkg::NEWLINE_CODE) begin
                           cursor_in = cursor_ff + PW'(COLUMNS) - PW'(col_ff);
                           col_in    = '0;
                        end else begin
                           wr_en     = 1'b1;
                           wr_addr   = cursor_ff[AW-1:0];
                           wr_data   = {req_ff.attribute, req_ff.char_code};
                           cursor_in = cursor_ff + PW'(1);
                           col_in    = (col_ff == CLW'(COLUMNS - 1)) ? '0
                                                                     : col_ff + CLW'(1);
                        end
                        rsp_valid_in     = 1'b1;
                        rsp_in           = '0;
                        rsp_in.cursor    = CurW'(cursor_in);
                        rsp_in.scrolled  = scrolled_ff;
                     end
                  end
                  tcw_pkg::MODE_READ: begin
                     rd_en    = 1'b1;
                     rd_addr  = ridx_wide[AW-1:0];
                     rd_ok_in = (ridx_wide < 32'(Cells));
                  end
                  tcw_pkg::MODE_CLEAR: begin
                     idx_in    = '0;
                     report_in = 1'b1;
                  end
                  tcw_pkg::MODE_BACK: begin
                     wr_en         = 1'b1;
                     wr_addr       = bs_cursor[AW-1:0];
                     wr_data       = {8'd0, tcw_pkg::SPACE_CODE};
                     cursor_in     = bs_cursor;
                     col_in        = bs_col;
                     rsp_valid_in  = 1'b1;
                     rsp_in        = '0;
                     rsp_in.cursor = CurW'(bs_cursor);
                  end
               endcase
            end
         end
         tcw_pkg::ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_in        = '0;
            rsp_in.cursor = CurW'(cursor_ff);
            if (rd_ok_ff) begin
               rsp_in.cell_char = rd_data[7:0];
               rsp_in.cell_attr = rd_data[15:8];
            end
         end
         tcw_pkg::ST_COPY: begin
            // Read one row below, write it back on the next cycle
            if (copy_more) begin
               rd_en        = 1'b1;
               rd_addr      = idx_ff + AW'(COLUMNS);
               pend_in      = 1'b1;
               pend_addr_in = idx_ff;
               idx_in       = idx_ff + AW'(1);
            end
         end
         tcw_pkg::ST_ZERO: begin
            // Clear the last row, then redo the put with the cursor on it
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = '0;
            idx_in  = idx_ff + AW'(1);
            if (idx_last) begin
               idx_in      = '0;
               cursor_in   = PW'(MoveN);
               col_in      = '0;
               scrolled_in = 1'b1;
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_CLEAR;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         cursor_ff    <= '0;
         col_ff       <= '0;
         report_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         report_ff    <= report_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      scrolled_ff  <= scrolled_in;
      rd_ok_ff     <= rd_ok_in;
      mode_ff      <= mode_in;
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(tcw_pkg::TDATA_W - RspW){1'b0}}, rsp_ff};

   // Cursor column stays within the row
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff < CLW'(COLUMNS - 1) || col_ff == CLW'(COLUMNS - 1))
      else $error("column out of range");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= PW'(Cells))
      else $error("cursor past end of screen");

   // A scroll only starts with the response register empty
   a_scroll_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_COPY || state_ff == tcw_pkg::ST_ZERO) |-> !rsp_valid_ff)
      else $error("response pending during scroll");

   // The copy never reads a cell it writes in the same cycle
   a_copy_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("read and write of the same cell");

endmodule

// ===== src/tcw_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
